// File: hw/rtl/otpt_pkg.sv
// ----------------------------------------------------------------------------
// otpt_pkg
// Shared constants, command/status structs and the arctangent tables.
// ----------------------------------------------------------------------------
package otpt_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int COORD_W    = 15;
  localparam int HEAD_W     = 9;
  localparam int ANG_W      = 7;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_W-1:0] SMALL_TURN_RST = 8'd5;
  localparam logic [CFG_W-1:0] SHORT_EDGE_RST = 8'd10;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_TURN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_EDGE = 1'b1;

  // trig tables: cos/sin of whole degrees 0..89 in unsigned q40
  localparam int ANG_N   = 90;
  localparam int TRIG_EW = 41;
  localparam int TRIG_W  = ANG_N * TRIG_EW;

  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
  localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // rotation by one degree, step built from taylor series in q62
  function automatic logic [TRIG_W-1:0] build_trig(input logic want_sin);
    logic [63:0] x, x2, x3, x4, x5, x6, x7, c1, s1, c, s, nc, ns;
    logic [TRIG_W-1:0] r;
    x  = PI_Q62 / 64'd180;
    x2 = mul_q62(x, x);
    x3 = mul_q62(x2, x);
    x4 = mul_q62(x2, x2);
    x5 = mul_q62(x4, x);
    x6 = mul_q62(x4, x2);
    x7 = mul_q62(x6, x);
    c1 = ONE_Q62 - x2 / 64'd2 + x4 / 64'd24 - x6 / 64'd720;
    s1 = x - x3 / 64'd6 + x5 / 64'd120 - x7 / 64'd5040;
    c  = ONE_Q62;
    s  = 64'd0;
    r  = '0;
    for (int k = 0; k < ANG_N; k++) begin
      r[k*TRIG_EW +: TRIG_EW] = want_sin ? s[62:22] : c[62:22];
      nc = mul_q62(c, c1) - mul_q62(s, s1);
      ns = mul_q62(s, c1) + mul_q62(c, s1);
      c  = nc;
      s  = ns;
    end
    return r;
  endfunction

  localparam logic [TRIG_W-1:0] COS_TAB = build_trig(1'b0);
  localparam logic [TRIG_W-1:0] SIN_TAB = build_trig(1'b1);

  typedef struct packed {
    logic              load_we;
    logic              xy_rd;
    logic [ADDR_W-1:0] xy_addr;
    logic              prev_ld;
    logic              diff_ld;
    logic              sq_a;
    logic              sq_b;
    logic              atan_start;
    logic              h_we;
    logic              h_rd;
    logic [ADDR_W-1:0] h_addr;
    logic              win_sh;
    logic              walk_clr;
    logic              decide;
    logic              finish;
  } otpt_cmd_t;

  typedef struct packed {
    logic atan_busy;
    logic decide_ok;
    logic out_free;
    logic held_v;
  } otpt_stat_t;

endpackage

// File: hw/rtl/otpt_atan.sv
// ----------------------------------------------------------------------------
// otpt_atan
// Whole-degree floor(atan(b/a)) by binary search over the trig tables.
// ----------------------------------------------------------------------------
module otpt_atan import otpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COORD_W-1:0] a_i,
  input  logic [COORD_W-1:0] b_i,
  output logic               busy_o,
  output logic [ANG_W-1:0]   angle_o
);

  localparam logic [ANG_W-1:0] ANG_EQ  = 7'd45;
  localparam logic [ANG_W-1:0] ANG_TOP = 7'd89;
  localparam logic [2:0]       STEP_DECIDE = 3'd4;

  logic               busy_q, busy_d;
  logic [ANG_W-1:0]   lo_q, lo_d, hi_q, hi_d, angle_q, angle_d;
  logic [2:0]         step_q, step_d;
  logic signed [57:0] acc_q, acc_d;

  logic [ANG_W:0]       mid_sum;
  logic [ANG_W-1:0]     mid;
  logic [TRIG_EW-1:0]   cos_v, sin_v, tab_v;
  logic [COORD_W-1:0]   mul_m;
  logic [20:0]          mul_t;
  logic [35:0]          prod;
  logic signed [57:0]   prod_lo, prod_hi;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 8'd1;
  assign mid     = mid_sum[ANG_W:1];
  assign cos_v   = COS_TAB[mid*TRIG_EW +: TRIG_EW];
  assign sin_v   = SIN_TAB[mid*TRIG_EW +: TRIG_EW];

  // steps 0,1: b*cos (low, high chunk); steps 2,3: a*sin
  assign tab_v = step_q[1] ? sin_v : cos_v;
  assign mul_m = step_q[1] ? a_i : b_i;
  assign mul_t = step_q[0] ? {1'b0, tab_v[40:21]} : tab_v[20:0];
  assign prod  = mul_m * mul_t;
  assign prod_lo = $signed({22'd0, prod});
  assign prod_hi = $signed({1'b0, prod, 21'd0});

  always_comb begin
    busy_d  = busy_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    step_d  = step_q;
    acc_d   = acc_q;
    angle_d = angle_q;
    if (start_i) begin
      if (a_i == b_i) begin
        angle_d = ANG_EQ;
        busy_d  = 1'b0;
      end else begin
        lo_d   = '0;
        hi_d   = ANG_TOP;
        step_d = '0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (lo_q == hi_q) begin
        angle_d = lo_q;
        busy_d  = 1'b0;
      end else begin
        case (step_q)
          3'd0: begin
            acc_d  = prod_lo;
            step_d = 3'd1;
          end
          3'd1: begin
            acc_d  = acc_q + prod_hi;
            step_d = 3'd2;
          end
          3'd2: begin
            acc_d  = acc_q - prod_lo;
            step_d = 3'd3;
          end
          3'd3: begin
            acc_d  = acc_q - prod_hi;
            step_d = STEP_DECIDE;
          end
          default: begin
            // probe holds when b*cos >= a*sin
            if (!acc_q[57]) lo_d = mid;
            else hi_d = mid - 7'd1;
            step_d = 3'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    acc_q   <= acc_d;
    angle_q <= angle_d;
  end

  assign busy_o  = busy_q;
  assign angle_o = angle_q;

endmodule

// File: hw/rtl/otpt_dpath.sv
// ----------------------------------------------------------------------------
// otpt_dpath
// Vertex and heading memories, edge arithmetic, walk window and result regs.
// ----------------------------------------------------------------------------
module otpt_dpath import otpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  otpt_cmd_t            cmd_i,
  output otpt_stat_t           stat_o,
  input  logic [COORD_W-1:0]   in_x_i,
  input  logic [COORD_W-1:0]   in_y_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [COORD_W-1:0]   out_x_o,
  output logic [COORD_W-1:0]   out_y_o,
  output logic                 out_last_o,
  output logic                 out_none_o
);

  function automatic logic [HEAD_W-1:0] wrap_turn(input logic [HEAD_W-1:0] hn,
                                                  input logic [HEAD_W-1:0] hp);
    logic signed [HEAD_W:0] d;
    d = $signed({hn[HEAD_W-1], hn}) - $signed({hp[HEAD_W-1], hp});
    if (d > 10'sd180) d = d - 10'sd360;
    else if (d < -10'sd180) d = d + 10'sd360;
    return d[HEAD_W-1:0];
  endfunction

  // config registers
  logic [CFG_W-1:0] lim_q, len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= SMALL_TURN_RST;
      len_q <= SHORT_EDGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SMALL_TURN: lim_q <= cfg_data_i;
        REG_SHORT_EDGE: len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // vertex memories
  logic [COORD_W-1:0] xmem [MAX_POINTS];
  logic [COORD_W-1:0] ymem [MAX_POINTS];
  logic [COORD_W-1:0] xr_q, yr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      xmem[cmd_i.xy_addr] <= in_x_i;
      ymem[cmd_i.xy_addr] <= in_y_i;
    end
    if (cmd_i.xy_rd) begin
      xr_q <= xmem[cmd_i.xy_addr];
      yr_q <= ymem[cmd_i.xy_addr];
    end
  end

  // edge arithmetic
  logic [COORD_W-1:0] px_q, py_q, a_q, b_q;
  logic [COORD_W:0]   dx_q, dy_q, dx_v, dy_v;
  logic [30:0]        sq_q;
  logic [29:0]        sq_p;
  logic [15:0]        len_sq;
  logic               edge_short;

  assign dx_v   = {1'b0, xr_q} - {1'b0, px_q};
  assign dy_v   = {1'b0, yr_q} - {1'b0, py_q};
  assign sq_p   = cmd_i.sq_b ? (b_q * b_q) : (a_q * a_q);
  assign len_sq = len_q * len_q;
  assign edge_short = sq_q < {15'd0, len_sq};

  always_ff @(posedge clk_i) begin
    if (cmd_i.prev_ld || cmd_i.diff_ld) begin
      px_q <= xr_q;
      py_q <= yr_q;
    end
    if (cmd_i.diff_ld) begin
      dx_q <= dx_v;
      dy_q <= dy_v;
      a_q  <= dx_v[COORD_W] ? COORD_W'(-dx_v) : dx_v[COORD_W-1:0];
      b_q  <= dy_v[COORD_W] ? COORD_W'(-dy_v) : dy_v[COORD_W-1:0];
    end
    if (cmd_i.sq_a) sq_q <= {1'b0, sq_p};
    else if (cmd_i.sq_b) sq_q <= sq_q + {1'b0, sq_p};
  end

  logic             atan_busy;
  logic [ANG_W-1:0] angle;

  otpt_atan u_atan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.atan_start),
    .a_i     (a_q),
    .b_i     (b_q),
    .busy_o  (atan_busy),
    .angle_o (angle)
  );

  // heading from the first-quadrant angle and the signs
  logic [7:0]        g;
  logic [HEAD_W-1:0] gx, head_v;

  always_comb begin
    if (dx_q[COORD_W]) g = (a_q == b_q) ? 8'd135 : 8'd179 - {1'b0, angle};
    else g = {1'b0, angle};
    gx = {1'b0, g};
    if (dx_q == '0 || dy_q == '0) head_v = '0;
    else if (dy_q[COORD_W]) head_v = HEAD_W'(0) - gx;
    else head_v = gx;
  end

  // heading memory, entry = {short, heading}
  logic [HEAD_W:0] hmem [MAX_POINTS];
  logic [HEAD_W:0] hr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.h_we) hmem[cmd_i.h_addr] <= {edge_short, head_v};
    if (cmd_i.h_rd) hr_q <= hmem[cmd_i.h_addr];
  end

  // walk window: headings at i-2..i+2, short flags of edges i-2..i+2
  logic [HEAD_W-1:0]  win_h_q [5];
  logic [4:0]         win_s_q;
  logic [COORD_W-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_sh) begin
      for (int k = 0; k < 4; k++) win_h_q[k] <= win_h_q[k+1];
      win_h_q[4] <= hr_q[HEAD_W-1:0];
      win_s_q    <= {hr_q[HEAD_W], win_s_q[4:1]};
      cx_q       <= xr_q;
      cy_q       <= yr_q;
    end
  end

  logic [HEAD_W-1:0] t_m1, t_0, t_p1, t_p2, abs_t, sum_q, sum_d;
  logic [HEAD_W:0]   s_v, abs_s;
  logic              pend_q, pend_d, keep, small_trn, flip;

  assign t_m1 = wrap_turn(win_h_q[1], win_h_q[0]);
  assign t_0  = wrap_turn(win_h_q[2], win_h_q[1]);
  assign t_p1 = wrap_turn(win_h_q[3], win_h_q[2]);
  assign t_p2 = wrap_turn(win_h_q[4], win_h_q[3]);

  assign abs_t = t_0[HEAD_W-1] ? HEAD_W'(0) - t_0 : t_0;
  assign small_trn = abs_t <= {1'b0, lim_q};
  assign s_v   = {sum_q[HEAD_W-1], sum_q} + {t_0[HEAD_W-1], t_0};
  assign abs_s = s_v[HEAD_W] ? (HEAD_W+1)'(0) - s_v : s_v;
  assign flip  = (t_m1[HEAD_W-1] == t_p1[HEAD_W-1]) && (t_m1[HEAD_W-1] == t_p2[HEAD_W-1])
              && (t_m1[HEAD_W-1] != t_0[HEAD_W-1]);

  always_comb begin
    sum_d  = sum_q;
    pend_d = pend_q;
    keep   = 1'b1;
    if (small_trn) begin
      if (abs_s <= {2'b00, lim_q}) begin
        keep   = 1'b0;
        sum_d  = s_v[HEAD_W-1:0];
        pend_d = 1'b1;
      end
    end else if (flip) begin
      // drop the lone flip next to a short edge once
      if ((win_s_q[1] || win_s_q[2]) && !pend_q) begin
        keep   = 1'b0;
        pend_d = 1'b1;
      end
    end
    if (keep) begin
      sum_d  = '0;
      pend_d = 1'b0;
    end
  end

  // held kept vertex and output register
  logic               held_v_q, out_v_q, out_last_q, out_none_q;
  logic [COORD_W-1:0] hx_q, hy_q, ox_q, oy_q;
  logic               out_free, dec_ok, dec_go, fin_go, push;

  assign out_free = !out_v_q || out_ready_i;
  assign dec_ok   = !(keep && held_v_q && !out_free);
  assign dec_go   = cmd_i.decide && dec_ok;
  assign fin_go   = cmd_i.finish && out_free;
  assign push     = (dec_go && keep && held_v_q) || fin_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      pend_q   <= 1'b0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cmd_i.walk_clr) begin
        sum_q    <= '0;
        pend_q   <= 1'b0;
        held_v_q <= 1'b0;
      end else if (dec_go) begin
        sum_q  <= sum_d;
        pend_q <= pend_d;
        if (keep) held_v_q <= 1'b1;
      end else if (fin_go) begin
        held_v_q <= 1'b0;
      end
      if (push) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_go && keep) begin
      hx_q <= cx_q;
      hy_q <= cy_q;
    end
    if (fin_go) begin
      ox_q       <= held_v_q ? hx_q : '0;
      oy_q       <= held_v_q ? hy_q : '0;
      out_last_q <= 1'b1;
      out_none_q <= !held_v_q;
    end else if (push) begin
      ox_q       <= hx_q;
      oy_q       <= hy_q;
      out_last_q <= 1'b0;
      out_none_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_last_o  = out_last_q;
  assign out_none_o  = out_none_q;

  assign stat_o.atan_busy = atan_busy;
  assign stat_o.decide_ok = dec_ok;
  assign stat_o.out_free  = out_free;
  assign stat_o.held_v    = held_v_q;

endmodule

// File: hw/rtl/otpt_ctrl.sv
// ----------------------------------------------------------------------------
// otpt_ctrl
// Sequencer: load, heading pass over all edges, then the keep/drop walk.
// ----------------------------------------------------------------------------
module otpt_ctrl import otpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  otpt_stat_t stat_i,
  output otpt_cmd_t  cmd_o
);

  localparam logic [3:0] ST_LOAD    = 4'd0;
  localparam logic [3:0] ST_P1_FRST = 4'd1;
  localparam logic [3:0] ST_P1_PREV = 4'd2;
  localparam logic [3:0] ST_P1_READ = 4'd3;
  localparam logic [3:0] ST_P1_DIFF = 4'd4;
  localparam logic [3:0] ST_P1_SQA  = 4'd5;
  localparam logic [3:0] ST_P1_SQB  = 4'd6;
  localparam logic [3:0] ST_P1_WAIT = 4'd7;
  localparam logic [3:0] ST_P3_RD   = 4'd8;
  localparam logic [3:0] ST_P3_SH   = 4'd9;
  localparam logic [3:0] ST_P3_DEC  = 4'd10;
  localparam logic [3:0] ST_P3_END  = 4'd11;

  localparam logic [2:0] PRIME_N = 3'd4;

  function automatic logic [ADDR_W-1:0] nxt(input logic [ADDR_W-1:0] v,
                                            input logic [ADDR_W-1:0] top);
    return (v == top) ? '0 : ADDR_W'(v + 1'b1);
  endfunction

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cm1, cm2;
  logic [ADDR_W-1:0] e_q, e_d, rc_q, rc_d, i_q, i_d, nm1, rc_start;
  logic [2:0]        prime_q, prime_d;

  assign cm1      = cnt_q - CNT_W'(1);
  assign cm2      = cnt_q - CNT_W'(2);
  assign nm1      = cm1[ADDR_W-1:0];
  assign rc_start = (cnt_q >= CNT_W'(2)) ? cm2[ADDR_W-1:0] : '0;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    e_d        = e_q;
    rc_d       = rc_q;
    i_d        = i_q;
    prime_d    = prime_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q != CNT_W'(MAX_POINTS)) begin
            cmd_o.load_we = 1'b1;
            cmd_o.xy_addr = cnt_q[ADDR_W-1:0];
            cnt_d         = cnt_q + CNT_W'(1);
          end
          if (in_last_i) state_d = ST_P1_FRST;
        end
      end
      ST_P1_FRST: begin
        cmd_o.walk_clr = 1'b1;
        cmd_o.xy_rd    = 1'b1;
        e_d            = '0;
        state_d        = ST_P1_PREV;
      end
      ST_P1_PREV: begin
        cmd_o.prev_ld = 1'b1;
        state_d       = ST_P1_READ;
      end
      ST_P1_READ: begin
        cmd_o.xy_rd   = 1'b1;
        cmd_o.xy_addr = nxt(e_q, nm1);
        state_d       = ST_P1_DIFF;
      end
      ST_P1_DIFF: begin
        cmd_o.diff_ld = 1'b1;
        state_d       = ST_P1_SQA;
      end
      ST_P1_SQA: begin
        cmd_o.sq_a = 1'b1;
        state_d    = ST_P1_SQB;
      end
      ST_P1_SQB: begin
        cmd_o.sq_b       = 1'b1;
        cmd_o.atan_start = 1'b1;
        state_d          = ST_P1_WAIT;
      end
      ST_P1_WAIT: begin
        if (!stat_i.atan_busy) begin
          cmd_o.h_we   = 1'b1;
          cmd_o.h_addr = e_q;
          if (e_q == nm1) begin
            rc_d    = rc_start;
            i_d     = '0;
            prime_d = '0;
            state_d = ST_P3_RD;
          end else begin
            e_d     = ADDR_W'(e_q + 1'b1);
            state_d = ST_P1_READ;
          end
        end
      end
      ST_P3_RD: begin
        cmd_o.h_rd    = 1'b1;
        cmd_o.h_addr  = rc_q;
        cmd_o.xy_rd   = 1'b1;
        cmd_o.xy_addr = i_q;
        rc_d          = nxt(rc_q, nm1);
        state_d       = ST_P3_SH;
      end
      ST_P3_SH: begin
        cmd_o.win_sh = 1'b1;
        if (prime_q != PRIME_N) begin
          prime_d = prime_q + 3'd1;
          state_d = ST_P3_RD;
        end else begin
          state_d = ST_P3_DEC;
        end
      end
      ST_P3_DEC: begin
        cmd_o.decide = 1'b1;
        if (stat_i.decide_ok) begin
          if (i_q == nm1) begin
            state_d = ST_P3_END;
          end else begin
            i_d     = ADDR_W'(i_q + 1'b1);
            state_d = ST_P3_RD;
          end
        end
      end
      ST_P3_END: begin
        cmd_o.finish = 1'b1;
        if (stat_i.out_free) begin
          cnt_d   = '0;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      e_q     <= '0;
      rc_q    <= '0;
      i_q     <= '0;
      prime_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      e_q     <= e_d;
      rc_q    <= rc_d;
      i_q     <= i_d;
      prime_q <= prime_d;
    end
  end

endmodule

// File: hw/rtl/outline_turn_point_thinner.sv
// ----------------------------------------------------------------------------
// outline_turn_point_thinner
// Thins a closed outline by dropping vertices whose turn is small or spurious.
// ----------------------------------------------------------------------------
// Vertices stream in one per cycle while the block is loading (up to 64 are
// stored, later ones dropped); the vertex with tlast set closes the outline
// and starts the walk, during which s_axis_tready is low. The walk first
// visits every edge: read, difference, squared-length and write-back work
// plus a whole-degree arctangent search, which probes the cos/sin table up
// to 7 times through one 15x21 multiplier (no search when |dx| equals |dy|).
// The keep/drop pass then fills its heading window and decides each vertex
// in turn, and stalls only while the output register is still full. Kept
// vertices leave in outline order; tlast marks the last one, and an outline
// with nothing kept yields a single zero item with tuser set.
// ----------------------------------------------------------------------------
module outline_turn_point_thinner import otpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // stream in, tdata: point_x [14:0], point_y [29:15], zero [31:30]
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,
  input  logic                 s_axis_tlast,   // is_final
  // stream out, tdata: out_x [14:0], out_y [29:15], zero [31:30]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,
  output logic                 m_axis_tlast,   // last_of_run
  output logic                 m_axis_tuser,   // none_kept
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  otpt_cmd_t          cmd;
  otpt_stat_t         stat;
  logic [COORD_W-1:0] ox, oy;

  // sequencer: load, heading pass, keep/drop walk
  otpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // memories, arithmetic and the output register
  otpt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_x_i      (s_axis_tdata[14:0]),
    .in_y_i      (s_axis_tdata[29:15]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_x_o     (ox),
    .out_y_o     (oy),
    .out_last_o  (m_axis_tlast),
    .out_none_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, oy, ox};

`ifndef SYNTHESIS
  // an empty result is always the only and last one, with zero coordinates
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 32'd0))
    else $error("none_kept result not last or not zero");

  // nothing from a previous walk is still held once loading resumes
  a_held_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !stat.held_v)
    else $error("held vertex left over while loading");

  // the arctangent unit is idle whenever new vertices are taken
  a_atan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !stat.atan_busy)
    else $error("arctangent unit busy while loading");
`endif

endmodule
